// ----- sv/trisol_pkg.sv -----
`timescale 1ns / 1ps
package trisol_pkg;
    localparam int MAX_ORDER_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int IO_WIDTH       = 32;
    localparam int ROW_LIMIT      = 16;

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_RHS    = 1'b1;

    localparam logic [0:0] REG_LOWER_MODE = 1'd0;
    localparam logic [0:0] REG_SIZE       = 1'd1;
endpackage

// ----- sv/trisol_if.sv -----
`timescale 1ns / 1ps
interface trisol_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] value;
    logic        last;
    modport source (output valid, kind, row, col, value, last, input ready);
    modport sink   (input valid, kind, row, col, value, last, output ready);
endinterface

interface trisol_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  row_res;
    logic signed [31:0] value_res;
    logic        divide_error;
    logic        last_res;
    modport source (output valid, row_res, value_res, divide_error, last_res, input ready);
    modport sink   (input valid, row_res, value_res, divide_error, last_res, output ready);
endinterface

// ----- sv/triangular_solve_core.sv -----
`timescale 1ns / 1ps
// channel   dir  payload                                  transfer when
// s_in      in   kind, row, col, value, last              valid & ready
// m_out     out  row_res, value_res, divide_error, last   valid & ready
// apb       in   lower_mode @0, size_in_use @4            psel & penable & pwrite
// matrix and rhs entries take one cycle each; a last rhs entry starts the solve
// solve: per pivot a registered read (PIV, PIVW), a bit-serial divide (none on a zero pivot or
// zero diagonal), then per row a read, multiply and write-back; a zero pivot updates no rows
// each result passes through read, load and transfer states; output stalls hold state
// input is not ready during solve and while results drain
// synchronous active-low reset clears control, sets lower_mode 0 and size 16; datapath and stores are undefined
module triangular_solve_core
    import trisol_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trisol_in_if.sink   s_in,
    trisol_out_if.source m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW   = $clog2(MAX_ORDER);
    localparam int CW   = $clog2(MAX_ORDER + 1);
    localparam int DW   = DATA_WIDTH;
    localparam int NLEN = DW + FRAC_BITS;
    localparam int DCW  = $clog2(NLEN + 1);
    localparam int LIM  = (MAX_ORDER < ROW_LIMIT) ? MAX_ORDER : ROW_LIMIT;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    localparam logic [3:0] ST_LOAD = 4'd0, ST_PIV = 4'd1, ST_PIVW = 4'd2,
        ST_DIV = 4'd3, ST_DIVF = 4'd4, ST_UPRD = 4'd5, ST_UPMUL = 4'd6,
        ST_UPWR = 4'd7, ST_OUTR = 4'd8, ST_OUT = 4'd9, ST_OUTW = 4'd10;

    // configuration
    logic       r_lower;
    logic [4:0] r_size;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= 1'b0;
            r_size  <= 5'd16;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOWER_MODE) r_lower <= pwdata[0];
            else r_size <= pwdata[4:0];
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_LOWER_MODE) prdata[0] = r_lower;
        else prdata[4:0] = r_size;
    end

    // effective order
    logic [CW-1:0] n_eff;
    always_comb begin
        if (r_size == 5'd0) n_eff = CW'(1);
        else if (32'(r_size) > LIM) n_eff = CW'(LIM);
        else n_eff = CW'(r_size);
    end

    // stores
    logic signed [DW-1:0] mem_mat [MAX_ORDER*MAX_ORDER];
    logic signed [DW-1:0] mem_vec [MAX_ORDER];
    logic [AW*2-1:0] mat_raddr;
    logic [AW-1:0]   vec_raddr;
    logic signed [DW-1:0] r_mat_q, r_vec_q;
    logic mat_we, vec_we;
    logic [AW*2-1:0] mat_waddr;
    logic [AW-1:0]   vec_waddr;
    logic signed [DW-1:0] mat_wdata, vec_wdata;
    always_ff @(posedge i_clk) begin
        if (mat_we) mem_mat[mat_waddr] <= mat_wdata;
        if (vec_we) mem_vec[vec_waddr] <= vec_wdata;
        r_mat_q <= mem_mat[mat_raddr];
        r_vec_q <= mem_vec[vec_raddr];
    end

    // sequencer registers
    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_s, n_s;
    logic [AW-1:0] r_k, n_k, r_i, n_i;
    logic [MAX_ORDER-1:0] r_err, n_err;
    logic signed [DW-1:0] r_xk, n_xk, r_xi, n_xi;
    logic signed [2*DW-1:0] r_prod, n_prod;
    logic [NLEN-1:0] r_num, n_num;
    logic [DW:0] r_rem, n_rem;
    logic [NLEN-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dmag, n_dmag;
    logic r_qneg, n_qneg;
    logic [DCW-1:0] r_dc, n_dc;
    logic          r_ov, n_ov;
    logic [3:0]    r_orow, n_orow;
    logic signed [DW-1:0] r_oval, n_oval;
    logic r_oerr, n_oerr, r_olast, n_olast;

    // input saturation to data width
    logic signed [DW-1:0] in_v;
    always_comb begin
        logic signed [63:0] w;
        w = 64'(s_in.value);
        if (w > 64'(MAXV)) in_v = MAXV;
        else if (w < 64'(MINV)) in_v = MINV;
        else in_v = DW'(w);
    end

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
        return a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

    // multiply result to saturated Q form
    logic signed [DW-1:0] mul_sat;
    always_comb begin
        logic [2*DW-1:0] pm;
        logic [2*DW-FRAC_BITS-1:0] t;
        logic neg;
        neg = r_prod[2*DW-1];
        pm  = neg ? (2*DW)'(-r_prod) : (2*DW)'(r_prod);
        t   = pm[2*DW-1:FRAC_BITS];
        if (neg) mul_sat = (t > (2*DW-FRAC_BITS)'(MAXV) + 1) ? MINV
                                : DW'(-$signed({1'b0, t}));
        else mul_sat = (t > (2*DW-FRAC_BITS)'(MAXV)) ? MAXV : DW'(t);
    end
    logic signed [DW:0] sub_w;
    logic signed [DW-1:0] sub_sat;
    always_comb begin
        sub_w = (DW+1)'(r_xi) - (DW+1)'(mul_sat);
        if (sub_w > (DW+1)'(MAXV)) sub_sat = MAXV;
        else if (sub_w < (DW+1)'(MINV)) sub_sat = MINV;
        else sub_sat = DW'(sub_w);
    end
    // divider step
    logic [DW:0] rem_sh;
    assign rem_sh = {r_rem[DW-1:0], r_num[NLEN-1]};

    logic busy_last;
    assign s_in.ready = (r_st == ST_LOAD);
    assign m_out.valid = (r_st == ST_OUT);
    assign m_out.row_res = r_orow;
    assign m_out.value_res = IO_WIDTH'(r_oval);
    assign m_out.divide_error = r_oerr;
    assign m_out.last_res = r_olast;
    assign busy_last = s_in.valid && s_in.kind == KIND_RHS && s_in.last;

    always_comb begin
        logic [DW-1:0] qm;
        n_st = r_st; n_s = r_s; n_k = r_k; n_i = r_i; n_err = r_err;
        n_xk = r_xk; n_xi = r_xi; n_prod = r_prod; n_num = r_num;
        n_rem = r_rem; n_quo = r_quo; n_dmag = r_dmag; n_qneg = r_qneg;
        n_dc = r_dc; n_ov = r_ov; n_orow = r_orow; n_oval = r_oval;
        n_oerr = r_oerr; n_olast = r_olast;
        mat_we = 1'b0; vec_we = 1'b0;
        mat_waddr = {AW'(s_in.row), AW'(s_in.col)};
        vec_waddr = AW'(s_in.row);
        mat_wdata = in_v; vec_wdata = in_v;
        mat_raddr = {r_k, r_k};
        vec_raddr = r_k;
        qm = '0;
        unique case (r_st)
            ST_LOAD: begin
                if (s_in.valid) begin
                    if (s_in.kind == KIND_MATRIX) begin
                        mat_we = (32'(s_in.row) < MAX_ORDER) && (32'(s_in.col) < MAX_ORDER);
                    end else begin
                        vec_we = 32'(s_in.row) < 32'(n_eff);
                        if (busy_last) begin
                            n_st = ST_PIV; n_s = '0; n_err = '0;
                            n_k = r_lower ? '0 : AW'(n_eff - 1'b1);
                        end
                    end
                end
            end
            ST_PIV: begin
                vec_raddr = r_k; mat_raddr = {r_k, r_k};
                n_st = ST_PIVW;
            end
            ST_PIVW: begin
                n_xk = r_vec_q;
                if (r_vec_q == '0) begin
                    n_st = ST_UPWR; n_i = r_k; // skip pivot
                    n_s = r_s;
                end else if (r_mat_q == '0) begin
                    n_err[r_k] = 1'b1;
                    n_xk = r_vec_q[DW-1] ? MINV : MAXV;
                    n_st = ST_DIVF; n_ov = 1'b0; n_quo = '0; n_dc = '0;
                end else begin
                    n_num = {mag(r_vec_q), {FRAC_BITS{1'b0}}};
                    n_dmag = mag(r_mat_q);
                    n_qneg = r_vec_q[DW-1] ^ r_mat_q[DW-1];
                    n_rem = '0; n_quo = '0; n_dc = DCW'(NLEN);
                    n_st = ST_DIV;
                end
            end
            ST_DIV: begin
                n_num = r_num << 1;
                if (rem_sh >= {1'b0, r_dmag}) begin
                    n_rem = rem_sh - {1'b0, r_dmag};
                    n_quo = {r_quo[NLEN-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[NLEN-2:0], 1'b0};
                end
                n_dc = r_dc - 1'b1;
                if (r_dc == DCW'(1)) begin
                    n_st = ST_DIVF; n_ov = 1'b1;
                end
            end
            ST_DIVF: begin
                if (r_ov) begin
                    qm = r_quo[DW-1:0];
                    if (r_qneg) n_xk = (r_quo > NLEN'(MAXV) + 1) ? MINV
                                       : DW'(-$signed({1'b0, qm}));
                    else n_xk = (r_quo > NLEN'(MAXV)) ? MAXV : DW'(qm);
                end
                vec_we = 1'b1; vec_waddr = r_k; vec_wdata = n_xk;
                n_i = r_lower ? AW'(r_k + 1'b1) : '0;
                if (r_lower ? (CW'(r_k) + 1'b1 >= n_eff) : (r_k == '0)) begin
                    n_st = ST_UPWR; n_i = r_k;
                end else n_st = ST_UPRD;
            end
            ST_UPRD: begin
                vec_raddr = r_i; mat_raddr = {r_i, r_k};
                n_st = ST_UPMUL;
            end
            ST_UPMUL: begin
                n_xi = r_vec_q;
                n_prod = r_xk * r_mat_q;
                n_st = ST_UPWR;
            end
            ST_UPWR: begin
                if (r_i != r_k) begin
                    vec_we = 1'b1; vec_waddr = r_i; vec_wdata = sub_sat;
                end
                if (r_i != r_k && (r_lower ? (CW'(r_i) + 1'b1 < n_eff)
                                           : (r_i + 1'b1 != r_k))) begin
                    n_i = r_i + 1'b1; n_st = ST_UPRD;
                end else if (r_s + 1'b1 >= n_eff) begin
                    n_st = ST_OUTR; n_i = '0;
                end else begin
                    n_s = r_s + 1'b1;
                    n_k = r_lower ? r_k + 1'b1 : r_k - 1'b1;
                    n_st = ST_PIV;
                end
            end
            ST_OUTR: begin
                vec_raddr = r_i;
                n_st = ST_OUTW; // wait for read data
            end
            ST_OUTW: begin
                n_orow = 4'(r_i); n_oval = r_vec_q; n_oerr = r_err[r_i];
                n_olast = (CW'(r_i) + 1'b1 == n_eff);
                n_st = ST_OUT;
            end
            ST_OUT: begin
                if (m_out.ready) begin
                    if (r_olast) n_st = ST_LOAD;
                    else begin
                        n_i = r_i + 1'b1; n_st = ST_OUTR;
                    end
                end
            end
            default: begin
                n_st = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_s <= '0; r_k <= '0; r_i <= '0; r_err <= '0;
            r_dc <= '0; r_ov <= 1'b0; r_olast <= 1'b0;
        end else begin
            r_st <= n_st; r_s <= n_s; r_k <= n_k; r_i <= n_i; r_err <= n_err;
            r_dc <= n_dc; r_ov <= n_ov; r_olast <= n_olast;
        end
        r_xk <= n_xk; r_xi <= n_xi; r_prod <= n_prod; r_num <= n_num;
        r_rem <= n_rem; r_quo <= n_quo; r_dmag <= n_dmag; r_qneg <= n_qneg;
        r_orow <= n_orow; r_oval <= n_oval; r_oerr <= n_oerr;
    end

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> !m_out.valid) else $error("input ready while results pending");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready && busy_last) |=> r_st == ST_PIV)
        else $error("solve did not start");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV && r_dc == DCW'(1)) |=> r_st == ST_DIVF)
        else $error("divide did not finish");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.ready && m_out.last_res) |=> s_in.ready)
        else $error("not idle after last result");
endmodule
